// File: design/gidemod_pkg.sv
// shared types, constants and helpers for the goertzel i/q demodulator
// no dependencies; used by controller, datapath, divider and top level
package gidemod_pkg;

  localparam int SAMPLE_BITS = 12;
  localparam int INPUT_SHIFT = 2;
  localparam int CFG_IDX_BITS = 3;

  localparam logic [31:0] DCO_RESET = 32'd0 - (32'd1 << (SAMPLE_BITS - 1 + INPUT_SHIFT));

  localparam logic [31:0] COS_RESET = 32'd873460290;
  localparam logic [31:0] SIN_RESET = 32'd1961823932;
  localparam logic [15:0] BLEN_RESET = 16'd1024;
  localparam logic [4:0] ATT_RESET = 5'd4;
  localparam logic [15:0] ADVC_RESET = 16'hF29F; // -3425
  localparam logic [15:0] ADVS_RESET = 16'd32588;

  localparam logic [31:0] SEED_SCALE = 32'd26100;
  localparam logic [31:0] PHASOR_MIN = 32'd32760;
  localparam logic [31:0] AVG_MAX = 32'd8388607;
  localparam logic [31:0] AVG_MIN = 32'd2048;

  typedef enum logic [2:0] {
    REG_COS = 3'd0,
    REG_SIN = 3'd1,
    REG_BLEN = 3'd2,
    REG_ATT = 3'd3,
    REG_ADVC = 3'd4,
    REG_ADVS = 3'd5
  } reg_idx_t;

  typedef enum logic [5:0] {
    S_IDLE, S_REC, S_IQ0, S_IQ1, S_IQ2, S_PH1, S_PH2, S_PH3, S_PH4,
    S_L1, S_L2, S_L3, S_L4, S_D1, S_W1, S_D2, S_W2, S_PHFIX,
    S_R1, S_R2, S_R3, S_R4, S_R5, S_AVG, S_DC, S_WDC, S_DX, S_WX,
    S_DY, S_WY, S_FIN
  } state_t;

  typedef enum logic [5:0] {
    OP_NONE, OP_ACCEPT, OP_REC, OP_IQ0, OP_IQ1, OP_IQ2, OP_PH1, OP_PH2,
    OP_PH3, OP_PH4, OP_L1, OP_L2, OP_L3, OP_L4, OP_D1, OP_W1, OP_D2,
    OP_W2, OP_PHFIX, OP_R1, OP_R2, OP_R3, OP_R4, OP_R5, OP_AVG, OP_DC,
    OP_WDC, OP_DX, OP_WX, OP_DY, OP_WY, OP_FIN
  } op_t;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    logic block_end;
    logic div_done;
    logic out_free;
  } status_t;

  function automatic logic [31:0] abs32(input logic [31:0] x);
    return x[31] ? 32'd0 - x : x;
  endfunction

endpackage

// File: design/gidemod_div.sv
// iterative signed divider, one quotient bit per cycle, truncating
// uses gidemod_pkg; zero divisor gives all ones
module gidemod_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [31:0] divisor,
  output logic [31:0] quotient,
  output logic        done
);
  import gidemod_pkg::*;

  logic        busy;
  logic [4:0]  cnt;
  logic [31:0] rem;
  logic [31:0] dvd;
  logic [31:0] ub;
  logic        neg;
  logic [32:0] trial;

  assign trial = {rem, dvd[31]} - {1'b0, ub};
  assign quotient = neg ? 32'd0 - dvd : dvd;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        if (divisor == 32'd0) begin
          dvd <= '1;
          neg <= 1'b0;
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          dvd <= abs32(dividend);
          ub <= abs32(divisor);
          rem <= '0;
          neg <= dividend[31] ^ divisor[31];
          cnt <= '0;
          busy <= 1'b1;
        end
      end else if (busy) begin
        if (!trial[32]) begin
          rem <= trial[31:0];
          dvd <= {dvd[30:0], 1'b1};
        end else begin
          rem <= {rem[30:0], dvd[31]};
          dvd <= {dvd[30:0], 1'b0};
        end
        cnt <= cnt + 5'd1;
        if (cnt == 5'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// File: design/gidemod_ctrl.sv
// sequencer for per-sample recursion and the end-of-block epilogue
// uses gidemod_pkg; drives the datapath by op codes
module gidemod_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  gidemod_pkg::status_t st,
  output gidemod_pkg::cmd_t    cmd
);
  import gidemod_pkg::*;

  state_t state, state_next;
  logic   len_mag, len_mag_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      len_mag <= 1'b0;
    end else begin
      state <= state_next;
      len_mag <= len_mag_next;
    end
  end

  always_comb begin
    state_next = state;
    len_mag_next = len_mag;
    case (state)
      S_IDLE: if (in_valid) state_next = S_REC;
      S_REC: state_next = st.block_end ? S_IQ0 : S_IDLE;
      S_IQ0: state_next = S_IQ1;
      S_IQ1: state_next = S_IQ2;
      S_IQ2: state_next = S_PH1;
      S_PH1: state_next = S_PH2;
      S_PH2: state_next = S_PH3;
      S_PH3: state_next = S_PH4;
      S_PH4: begin
        state_next = S_L1;
        len_mag_next = 1'b0;
      end
      S_L1: state_next = S_L2;
      S_L2: state_next = S_L3;
      S_L3: state_next = S_L4;
      S_L4: state_next = S_D1;
      S_D1: state_next = S_W1;
      S_W1: if (st.div_done) state_next = S_D2;
      S_D2: state_next = S_W2;
      S_W2: if (st.div_done) state_next = len_mag ? S_AVG : S_PHFIX;
      S_PHFIX: state_next = S_R1;
      S_R1: state_next = S_R2;
      S_R2: state_next = S_R3;
      S_R3: state_next = S_R4;
      S_R4: state_next = S_R5;
      S_R5: begin
        state_next = S_L1;
        len_mag_next = 1'b1;
      end
      S_AVG: state_next = S_DC;
      S_DC: state_next = S_WDC;
      S_WDC: if (st.div_done) state_next = S_DX;
      S_DX: state_next = S_WX;
      S_WX: if (st.div_done) state_next = S_DY;
      S_DY: state_next = S_WY;
      S_WY: if (st.div_done) state_next = S_FIN;
      S_FIN: if (st.out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    cmd.op = OP_NONE;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) cmd.op = OP_ACCEPT;
      end
      S_REC: cmd.op = OP_REC;
      S_IQ0: cmd.op = OP_IQ0;
      S_IQ1: cmd.op = OP_IQ1;
      S_IQ2: cmd.op = OP_IQ2;
      S_PH1: cmd.op = OP_PH1;
      S_PH2: cmd.op = OP_PH2;
      S_PH3: cmd.op = OP_PH3;
      S_PH4: cmd.op = OP_PH4;
      S_L1: cmd.op = OP_L1;
      S_L2: cmd.op = OP_L2;
      S_L3: cmd.op = OP_L3;
      S_L4: cmd.op = OP_L4;
      S_D1: cmd.op = OP_D1;
      S_W1: cmd.op = OP_W1;
      S_D2: cmd.op = OP_D2;
      S_W2: cmd.op = OP_W2;
      S_PHFIX: cmd.op = OP_PHFIX;
      S_R1: cmd.op = OP_R1;
      S_R2: cmd.op = OP_R2;
      S_R3: cmd.op = OP_R3;
      S_R4: cmd.op = OP_R4;
      S_R5: cmd.op = OP_R5;
      S_AVG: cmd.op = OP_AVG;
      S_DC: cmd.op = OP_DC;
      S_WDC: cmd.op = OP_WDC;
      S_DX: cmd.op = OP_DX;
      S_WX: cmd.op = OP_WX;
      S_DY: cmd.op = OP_DY;
      S_WY: cmd.op = OP_WY;
      S_FIN: if (st.out_free) cmd.op = OP_FIN;
      default: cmd.op = OP_NONE;
    endcase
  end

endmodule

// File: design/gidemod_dp.sv
// datapath: config registers, recursion state, shared multiplier, divider
// uses gidemod_pkg and gidemod_div
module gidemod_dp (
  input  logic                                  clk,
  input  logic                                  rst,
  input  gidemod_pkg::cmd_t                     cmd,
  output gidemod_pkg::status_t                  st,
  input  logic                                  cfg_valid,
  input  logic [gidemod_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [31:0]                           cfg_data,
  input  logic [gidemod_pkg::SAMPLE_BITS-1:0]   sample,
  input  logic                                  out_ready,
  output logic                                  out_valid,
  output logic signed [31:0]                    in_phase,
  output logic signed [31:0]                    quadrature,
  output logic [30:0]                           magnitude,
  output logic [22:0]                           level_avg,
  output logic [6:0]                            plot_x,
  output logic [6:0]                            plot_y
);
  import gidemod_pkg::*;

  logic signed [31:0] cos_c, sin_c;
  logic [15:0]        blen;
  logic [4:0]         att;
  logic signed [15:0] adv_c, adv_s;

  logic [31:0] rec_now, rec_prev, wsum, dco, t_reg;
  logic [15:0] cnt;
  logic signed [17:0] ph_r, ph_i;
  logic [23:0] lavg;
  logic signed [63:0] prod;
  logic [31:0] acc, tmp, rr, ri, la, lb, s_reg, e_reg, avg_reg;
  logic [6:0]  x_reg, y_reg;

  logic signed [31:0] mul_a, mul_b;
  logic [31:0] pr32, pi32, ar32, ai32, t_in, iq_sh, fix_r, fix_i;
  logic signed [63:0] p2;
  logic [31:0] div_a, div_b, div_q, seed, half, esum, av0, av1, avc, divisor;
  logic div_start, div_done;

  function automatic logic [31:0] asr32(input logic [31:0] x, input logic [4:0] n);
    return $signed(x) >>> n;
  endfunction

  function automatic logic [6:0] clamp_plot(input logic [31:0] q);
    logic signed [31:0] v;
    v = $signed(q + 32'd64);
    if (v < 32'sd1) return 7'd1;
    else if (v > 32'sd126) return 7'd126;
    else return v[6:0];
  endfunction

  assign pr32 = 32'(ph_r);
  assign pi32 = 32'(ph_i);
  assign ar32 = 32'(adv_c);
  assign ai32 = 32'(adv_s);
  assign t_in = (32'(sample) << INPUT_SHIFT) + dco;
  assign p2 = {prod[62:0], 1'b0};
  assign iq_sh = 32'(p2 >>> {1'b1, att});
  assign seed = abs32(prod[31:0]) >> 15;
  // newton step halves the sum, truncating toward zero
  assign esum = e_reg + div_q;
  assign half = abs32(esum) >> 1;
  assign fix_r = la + asr32(la, 5'd12);
  assign fix_i = lb + asr32(lb, 5'd12);
  assign av0 = 32'($signed(lavg));
  assign av1 = av0 - asr32(av0, 5'd12) + asr32(e_reg, 5'd6);
  assign divisor = (blen == 16'd0) ? 32'd65536 : 32'(blen);

  always_comb begin
    if ($signed(av1) >= $signed(AVG_MAX + 32'd1)) avc = AVG_MAX;
    else if ($signed(av1) < $signed(AVG_MIN)) avc = AVG_MIN;
    else avc = av1;
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      OP_ACCEPT, OP_IQ0: begin
        mul_a = cos_c;
        mul_b = rec_now;
      end
      OP_IQ1: begin
        mul_a = sin_c;
        mul_b = rec_now;
      end
      OP_IQ2: begin mul_a = pr32; mul_b = ai32; end
      OP_PH1: begin mul_a = pi32; mul_b = ar32; end
      OP_PH2: begin mul_a = pr32; mul_b = ar32; end
      OP_PH3: begin mul_a = pi32; mul_b = ai32; end
      OP_L1: begin mul_a = la; mul_b = la; end
      OP_L2: begin mul_a = lb; mul_b = lb; end
      OP_L3: begin mul_a = abs32(la) + abs32(lb); mul_b = SEED_SCALE; end
      OP_R1: begin mul_a = pr32; mul_b = ri; end
      OP_R2: begin mul_a = pi32; mul_b = rr; end
      OP_R3: begin mul_a = pr32; mul_b = rr; end
      OP_R4: begin mul_a = pi32; mul_b = ri; end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  always_comb begin
    div_start = 1'b0;
    div_a = s_reg;
    div_b = e_reg;
    case (cmd.op)
      OP_D1, OP_D2: div_start = 1'b1;
      OP_DC: begin
        div_start = 1'b1;
        div_a = wsum;
        div_b = divisor;
      end
      OP_DX: begin
        div_start = 1'b1;
        div_a = (rr << 10) + (rr << 9);
        div_b = avg_reg;
      end
      OP_DY: begin
        div_start = 1'b1;
        div_a = (ri << 10) + (ri << 9);
        div_b = avg_reg;
      end
      default: div_start = 1'b0;
    endcase
  end

  gidemod_div u_div (
    .clk(clk),
    .rst(rst),
    .start(div_start),
    .dividend(div_a),
    .divisor(div_b),
    .quotient(div_q),
    .done(div_done)
  );

  assign st.block_end = (cnt == blen);
  assign st.div_done = div_done;
  assign st.out_free = !out_valid || out_ready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cos_c <= COS_RESET;
      sin_c <= SIN_RESET;
      blen <= BLEN_RESET;
      att <= ATT_RESET;
      adv_c <= ADVC_RESET;
      adv_s <= ADVS_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_COS: cos_c <= cfg_data;
        REG_SIN: sin_c <= cfg_data;
        REG_BLEN: blen <= cfg_data[15:0];
        REG_ATT: att <= cfg_data[4:0];
        REG_ADVC: adv_c <= cfg_data[15:0];
        REG_ADVS: adv_s <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    case (cmd.op)
      OP_ACCEPT: t_reg <= t_in;
      OP_IQ1: rr <= iq_sh - asr32(rec_prev, att);
      OP_IQ2: ri <= iq_sh;
      OP_PH1, OP_PH3, OP_L2, OP_R2, OP_R4: acc <= prod[31:0];
      OP_PH2, OP_R3: tmp <= asr32(acc + prod[31:0], 5'd15);
      OP_PH4: begin
        la <= asr32(acc - prod[31:0], 5'd15);
        lb <= tmp;
      end
      OP_L3: s_reg <= acc + prod[31:0];
      OP_L4: e_reg <= (prod[31] ? 32'd0 - seed : seed) + 32'd1;
      OP_W1, OP_W2: if (div_done) e_reg <= esum[31] ? 32'd0 - half : half;
      OP_R5: begin
        rr <= asr32(acc - prod[31:0], 5'd15);
        ri <= tmp;
        la <= asr32(acc - prod[31:0], 5'd15);
        lb <= tmp;
      end
      OP_AVG: avg_reg <= avc;
      OP_WX: if (div_done) x_reg <= clamp_plot(div_q);
      OP_WY: if (div_done) y_reg <= clamp_plot(div_q);
      default: ;
    endcase
  end

  // recursion and block state
  always_ff @(posedge clk) begin
    if (rst) begin
      rec_now <= '0;
      rec_prev <= '0;
      cnt <= '0;
      wsum <= '0;
      dco <= DCO_RESET;
      ph_r <= 18'sd32768;
      ph_i <= '0;
      lavg <= 24'd1;
      out_valid <= 1'b0;
    end else begin
      if (cmd.op == OP_FIN) out_valid <= 1'b1;
      else if (out_valid && out_ready) out_valid <= 1'b0;
      case (cmd.op)
        OP_ACCEPT: begin
          wsum <= wsum + t_in;
          cnt <= cnt + 16'd1;
        end
        OP_REC: begin
          rec_prev <= rec_now;
          rec_now <= t_reg + prod[61:30] - rec_prev;
        end
        OP_PHFIX: begin
          if ($signed(e_reg) < $signed(PHASOR_MIN)) begin
            ph_r <= fix_r[17:0];
            ph_i <= fix_i[17:0];
          end else begin
            ph_r <= la[17:0];
            ph_i <= lb[17:0];
          end
        end
        OP_AVG: lavg <= avc[23:0];
        OP_WDC: if (div_done) dco <= dco - div_q;
        OP_FIN: begin
          rec_now <= '0;
          rec_prev <= '0;
          cnt <= '0;
          wsum <= '0;
        end
        default: ;
      endcase
    end
  end

  // result register, loaded once per block
  always_ff @(posedge clk) begin
    if (cmd.op == OP_FIN) begin
      in_phase <= rr;
      quadrature <= ri;
      magnitude <= e_reg[30:0];
      level_avg <= avg_reg[22:0];
      plot_x <= x_reg;
      plot_y <= y_reg;
    end
  end

endmodule

// File: design/goertzel_iq_demodulator_top.sv
// top level of the goertzel i/q demodulator: controller, datapath, checks
// uses gidemod_pkg, gidemod_ctrl, gidemod_dp (which holds gidemod_div)
//
//  channel | direction | signals
//  --------+-----------+------------------------------------------------
//  in      | input     | in_valid, in_ready, sample
//  out     | output    | out_valid, out_ready, in_phase .. plot_y
//  cfg     | input     | cfg_valid, cfg_ready, cfg_index, cfg_data
//
// each sample is accepted, then goes through the feedback multiply-add before the next is taken
// the item closing a block adds an epilogue, mostly set by
// seven passes of the shared bit-serial divider
// the epilogue waits in its last step while the previous result is not taken
// synchronous reset restores the register defaults and the dc offset
// cfg is always ready; write only while idle
module goertzel_iq_demodulator_top (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [gidemod_pkg::SAMPLE_BITS-1:0]   sample,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [31:0]                    in_phase,
  output logic signed [31:0]                    quadrature,
  output logic [30:0]                           magnitude,
  output logic [22:0]                           level_avg,
  output logic [6:0]                            plot_x,
  output logic [6:0]                            plot_y,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [gidemod_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [31:0]                           cfg_data
);
  import gidemod_pkg::*;

  cmd_t    cmd;
  status_t st;

  assign cfg_ready = 1'b1;

  gidemod_ctrl u_ctrl (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .st(st),
    .cmd(cmd)
  );

  gidemod_dp u_dp (
    .clk(clk),
    .rst(rst),
    .cmd(cmd),
    .st(st),
    .cfg_valid(cfg_valid),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .sample(sample),
    .out_ready(out_ready),
    .out_valid(out_valid),
    .in_phase(in_phase),
    .quadrature(quadrature),
    .magnitude(magnitude),
    .level_avg(level_avg),
    .plot_x(plot_x),
    .plot_y(plot_y)
  );

  // an accepted item always spends the next cycle in the recursion step
  a_accept_then_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready && cmd.op == OP_REC)
    else $error("input taken twice in a row");

  // divider results only land while the sequencer waits for them
  a_div_done_waited: assert property (@(posedge clk) disable iff (rst)
    st.div_done |-> (cmd.op == OP_W1 || cmd.op == OP_W2 || cmd.op == OP_WDC ||
                     cmd.op == OP_WX || cmd.op == OP_WY))
    else $error("divider finished outside a wait step");

  // a new result appears only from the final epilogue step
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(cmd.op) == OP_FIN)
    else $error("result raised without finishing a block");

  // final step never overwrites a result still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.op == OP_FIN |-> !out_valid || out_ready)
    else $error("pending result overwritten");

endmodule

// File: dv/goertzel_iq_demodulator_checker.sv
// watches the sample, result and register channels of the goertzel i/q demodulator
// predicts every result item and compares it field by field; uses gidemod_pkg
module goertzel_iq_demodulator_checker (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  input  logic                                  in_ready,
  input  logic [gidemod_pkg::SAMPLE_BITS-1:0]   sample,
  input  logic                                  out_valid,
  input  logic                                  out_ready,
  input  logic signed [31:0]                    in_phase,
  input  logic signed [31:0]                    quadrature,
  input  logic [30:0]                           magnitude,
  input  logic [22:0]                           level_avg,
  input  logic [6:0]                            plot_x,
  input  logic [6:0]                            plot_y,
  input  logic                                  cfg_valid,
  input  logic                                  cfg_ready,
  input  logic [gidemod_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [31:0]                           cfg_data,
  output int                                    errors,
  output int                                    pending
);
  import gidemod_pkg::*;

  typedef struct {
    logic [31:0] i_val;
    logic [31:0] q_val;
    logic [30:0] mag;
    logic [22:0] avg;
    logic [6:0]  px;
    logic [6:0]  py;
  } block_result_t;

  block_result_t block_results[$];

  logic [31:0] r_cos, r_sin;
  logic [15:0] r_blen, r_advc, r_advs;
  logic [4:0]  r_att;
  logic [31:0] z_now, z_prev, win_sum, dc_off;
  logic [15:0] count;
  logic [17:0] ph_re, ph_im;
  logic [23:0] lvl;

  function automatic logic [31:0] sra(input logic [31:0] x, input int sh);
    logic signed [31:0] xs;
    xs = x;
    return xs >>> sh;
  endfunction

  function automatic logic [31:0] mag32(input logic [31:0] x);
    return x[31] ? 32'd0 - x : x;
  endfunction

  function automatic logic [31:0] quot(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] q;
    if (b == 0) return 32'hFFFF_FFFF;
    if (a == 32'h8000_0000 && b == 32'hFFFF_FFFF) return a;
    q = mag32(a) / mag32(b);
    if (a[31] ^ b[31]) q = 32'd0 - q;
    return q;
  endfunction

  // l1 seed then two newton steps
  function automatic logic [31:0] vec_len(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] s, e;
    s = a * a + b * b;
    e = quot((mag32(a) + mag32(b)) * 32'd26100, 32'd32768) + 32'd1;
    e = quot(e + quot(s, e), 32'd2);
    e = quot(e + quot(s, e), 32'd2);
    return e;
  endfunction

  function automatic logic [6:0] plot_pos(input logic [31:0] v);
    logic signed [31:0] x;
    x = v + 32'd64;
    if (x < 1) x = 1;
    if (x > 126) x = 126;
    return x[6:0];
  endfunction

  function automatic logic [31:0] mulshift(input logic [31:0] c, input logic [31:0] z,
                                           input int sh, input bit dbl);
    logic signed [63:0] a64, b64, p;
    a64 = $signed(c);
    b64 = $signed(z);
    p = a64 * b64;
    if (dbl) p = p <<< 1;
    p = p >>> sh;
    return p[31:0];
  endfunction

  task automatic take_sample(input logic [11:0] smp);
    logic [31:0] t, old_prev, rr, ri, pr, pi, ar, ai, tmp, mg, av;
    logic [31:0] divisor;
    block_result_t res;
    t = ({20'd0, smp} << INPUT_SHIFT) + dc_off;
    win_sum = win_sum + t;
    old_prev = z_prev;
    z_prev = z_now;
    z_now = t + mulshift(r_cos, z_prev, 30, 0) - old_prev;
    count = count + 16'd1;
    if (count != r_blen) return;

    rr = mulshift(r_cos, z_now, 32 + r_att, 1) - sra(z_prev, r_att);
    ri = mulshift(r_sin, z_now, 32 + r_att, 1);

    pr = {{14{ph_re[17]}}, ph_re};
    pi = {{14{ph_im[17]}}, ph_im};
    ar = {{16{r_advc[15]}}, r_advc};
    ai = {{16{r_advs[15]}}, r_advs};
    tmp = sra(pr * ai + pi * ar, 15);
    pr = sra(pr * ar - pi * ai, 15);
    pi = tmp;
    // renormalise when the phasor has shrunk
    if ($signed(vec_len(pr, pi)) < 32760) begin
      pr = pr + sra(pr, 12);
      pi = pi + sra(pi, 12);
    end
    ph_re = pr[17:0];
    ph_im = pi[17:0];
    pr = {{14{ph_re[17]}}, ph_re};
    pi = {{14{ph_im[17]}}, ph_im};

    tmp = sra(pr * ri + pi * rr, 15);
    rr = sra(pr * rr - pi * ri, 15);
    ri = tmp;
    mg = vec_len(rr, ri);

    av = {{8{lvl[23]}}, lvl};
    av = av - sra(av, 12) + sra(mg, 6);
    if ($signed(av) >= (1 <<< 23)) av = 32'd8388607;
    if ($signed(av) < 2048) av = 32'd2048;
    lvl = av[23:0];

    z_now = 0;
    z_prev = 0;
    count = 0;
    divisor = (r_blen != 0) ? {16'd0, r_blen} : 32'd65536;
    dc_off = dc_off - quot(win_sum, divisor);
    win_sum = 0;

    res.i_val = rr;
    res.q_val = ri;
    res.mag = mg[30:0];
    res.avg = av[22:0];
    res.px = plot_pos(quot(rr * 32'd1536, av));
    res.py = plot_pos(quot(ri * 32'd1536, av));
    block_results.push_back(res);
  endtask

  task automatic field_check(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    block_result_t exp_res;
    if (rst) begin
      r_cos = COS_RESET;
      r_sin = SIN_RESET;
      r_blen = BLEN_RESET;
      r_att = ATT_RESET;
      r_advc = ADVC_RESET;
      r_advs = ADVS_RESET;
      z_now = 0;
      z_prev = 0;
      count = 0;
      win_sum = 0;
      dc_off = DCO_RESET;
      ph_re = 18'd32768;
      ph_im = 0;
      lvl = 24'd1;
      block_results.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_COS:  r_cos = cfg_data;
          REG_SIN:  r_sin = cfg_data;
          REG_BLEN: r_blen = cfg_data[15:0];
          REG_ATT:  r_att = cfg_data[4:0];
          REG_ADVC: r_advc = cfg_data[15:0];
          REG_ADVS: r_advs = cfg_data[15:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) take_sample(sample);
      if (out_valid && out_ready) begin
        if (block_results.size() == 0) begin
          $error("result item with no expectation waiting");
          errors++;
        end else begin
          exp_res = block_results.pop_front();
          field_check("in_phase", exp_res.i_val, in_phase);
          field_check("quadrature", exp_res.q_val, quadrature);
          field_check("magnitude", {1'b0, exp_res.mag}, {1'b0, magnitude});
          field_check("level_avg", {9'd0, exp_res.avg}, {9'd0, level_avg});
          field_check("plot_x", {25'd0, exp_res.px}, {25'd0, plot_x});
          field_check("plot_y", {25'd0, exp_res.py}, {25'd0, plot_y});
        end
      end
    end
    pending <= block_results.size();
  end

endmodule

// File: dv/goertzel_iq_demodulator_top_test.sv
// testbench top for the goertzel i/q demodulator: clock, reset, stimulus and verdict
// depends on gidemod_pkg, goertzel_iq_demodulator_top and goertzel_iq_demodulator_checker
module goertzel_iq_demodulator_top_test;
  import gidemod_pkg::*;

  logic clk, rst;
  logic in_valid, in_ready, out_valid, out_ready, cfg_valid, cfg_ready;
  logic [SAMPLE_BITS-1:0] sample;
  logic signed [31:0] in_phase, quadrature;
  logic [30:0] magnitude;
  logic [22:0] level_avg;
  logic [6:0] plot_x, plot_y;
  logic [CFG_IDX_BITS-1:0] cfg_index;
  logic [31:0] cfg_data;
  int errors, pending;
  int send_idle, recv_idle;

  goertzel_iq_demodulator_top DUT (.*);

  goertzel_iq_demodulator_checker checker_i (.*);

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  initial begin
    #8_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  always @(negedge clk) out_ready <= ($urandom_range(99) >= recv_idle);

  task automatic send_sample(input logic [11:0] v);
    @(negedge clk);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 0;
      @(negedge clk);
    end
    in_valid <= 1;
    sample <= v;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [31:0] d);
    @(negedge clk);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= d;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 0;
  endtask

  // let the epilogue finish even when the last item closed no block
  task automatic drain();
    @(negedge clk);
    in_valid <= 0;
    while (pending != 0) @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  function automatic logic [31:0] pick32();
    case ($urandom_range(5))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] pick16();
    case ($urandom_range(5))
      0: return 32'h8000;
      1: return 32'h7FFF;
      2: return $urandom_range(32767, 32000);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [11:0] pick_sample();
    case ($urandom_range(7))
      0: return 12'd0;
      1: return 12'hFFF;
      default: return 12'($urandom);
    endcase
  endfunction

  initial begin
    int n, blen;
    rst = 1;
    in_valid = 0;
    sample = 0;
    cfg_valid = 0;
    cfg_index = REG_COS;
    cfg_data = 0;
    send_idle = 36;
    recv_idle = 51;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // directed: field extremes, both attenuation extremes, extreme coefficients
    write_reg(REG_BLEN, 32'd3);
    write_reg(REG_ATT, 32'd0);
    send_sample(12'd0);
    send_sample(12'hFFF);
    send_sample(12'hAAA);
    send_sample(12'h555);
    send_sample(12'hFFF);
    send_sample(12'hFFF);
    drain();
    write_reg(REG_COS, 32'h7FFF_FFFF);
    write_reg(REG_SIN, 32'h8000_0000);
    write_reg(REG_ATT, 32'd31);
    write_reg(REG_ADVC, 32'h8000);
    write_reg(REG_ADVS, 32'h7FFF);
    for (int i = 0; i < 6; i++) send_sample(i[0] ? 12'hFFF : 12'd0);
    drain();
    write_reg(REG_COS, 32'h8000_0000);
    write_reg(REG_SIN, 32'h7FFF_FFFF);
    write_reg(REG_BLEN, 32'd1);
    write_reg(REG_ADVC, 32'h7FFF);
    write_reg(REG_ADVS, 32'h8000);
    for (int i = 0; i < 6; i++) send_sample(i[1] ? 12'hFFF : 12'h800);
    drain();

    for (int p = 0; p < 90; p++) begin
      if (p < 30) begin
        send_idle = 36;
        recv_idle = 51;
      end else if (p < 60) begin
        send_idle = 51;
        recv_idle = 36;
      end else begin
        send_idle = 0;
        recv_idle = 0;
      end
      if ($urandom_range(1)) write_reg(REG_COS, pick32());
      if ($urandom_range(1)) write_reg(REG_SIN, pick32());
      if ($urandom_range(1)) write_reg(REG_ATT, $urandom_range(3) == 0 ?
                                       ($urandom_range(1) ? 31 : 0) : $urandom);
      if ($urandom_range(1)) write_reg(REG_ADVC, pick16());
      if ($urandom_range(1)) write_reg(REG_ADVS, pick16());
      blen = $urandom_range(12, 1);
      write_reg(REG_BLEN, blen);
      // mostly whole blocks, sometimes a partial tail
      n = blen * $urandom_range(3, 1) + ($urandom_range(3) == 0 ? $urandom_range(blen) : 0);
      for (int i = 0; i < n; i++) send_sample(pick_sample());
      drain();
    end

    // zero length: the counter runs on past every small length
    write_reg(REG_BLEN, 32'd0);
    for (int i = 0; i < 300; i++) send_sample(pick_sample());
    drain();
    write_reg(REG_BLEN, 32'd350);
    for (int i = 0; i < 50; i++) send_sample(pick_sample());
    drain();
    write_reg(REG_BLEN, 32'd7);
    for (int i = 0; i < 3; i++) send_sample(pick_sample());
    drain();
    write_reg(REG_BLEN, 32'd5);
    for (int i = 0; i < 2; i++) send_sample(pick_sample());
    drain();

    if (errors == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
